// ===== rtl/ultrasonic_echo_ranger_core_assert.svh =====
// Assertion macros for the ultrasonic echo ranger checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define UER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check the consequent in the cycle after the antecedent
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/uer_pkg.sv =====
// Shared constants, codes and control types of the ultrasonic echo ranger.
// No dependencies; every other file but the assertion header imports this package.
package uer_pkg;

    localparam int TIMER_BITS_DEF  = 20;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int CFG_TMO_W       = 20;
    localparam int RATIO_W         = 8;
    localparam int OVH_W           = 8;
    localparam int STATUS_W        = 2;
    localparam int DIST_W          = 27;

    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;

    localparam int APB_DW          = 32;
    localparam int APB_AW          = 4;

    localparam logic [1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [1:0] REG_RATIO_CM   = 2'd1;
    localparam logic [1:0] REG_RATIO_INCH = 2'd2;
    localparam logic [1:0] REG_OVERHEAD   = 2'd3;

    localparam logic [CFG_TMO_W-1:0] TIMEOUT_RST    = CFG_TMO_W'(23200);
    localparam logic [RATIO_W-1:0]   RATIO_CM_RST   = RATIO_W'(29);
    localparam logic [RATIO_W-1:0]   RATIO_INCH_RST = RATIO_W'(74);
    localparam logic [OVH_W-1:0]     OVERHEAD_RST   = OVH_W'(20);

    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ECHO      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

    localparam logic [1:0] TMR_HOLD  = 2'd0;
    localparam logic [1:0] TMR_CLEAR = 2'd1;
    localparam logic [1:0] TMR_SET1  = 2'd2;
    localparam logic [1:0] TMR_INCR  = 2'd3;

    localparam logic [1:0] WC_HOLD  = 2'd0;
    localparam logic [1:0] WC_CLEAR = 2'd1;
    localparam logic [1:0] WC_SET1  = 2'd2;
    localparam logic [1:0] WC_INCR  = 2'd3;

    typedef struct packed {
        logic [1:0]          tmr_op;
        logic [1:0]          wc_op;
        logic                units_load;
        logic                res_load;
        logic                res_trig;
        logic                res_busy;
        logic                res_done;
        logic [STATUS_W-1:0] res_status;
        logic                res_dist_en;
        logic                div_start;
        logic                div_step;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic tmr_ge_low;
        logic tmr_ge_high;
        logic tmr_ge_tmo;
        logic wc_ge_tmo;
        logic tmo_zero;
        logic div_last;
    } sts_t;

endpackage

// ===== rtl/uer_if.sv =====
// Input and output channel interfaces of the ultrasonic echo ranger.
// Depends on uer_pkg for field widths.
interface uer_in_if import uer_pkg::*; ();
    logic valid;
    logic ready;
    logic start_req;
    logic use_inches;
    logic echo_level;

    modport source (output valid, output start_req, output use_inches, output echo_level,
                    input ready);
    modport sink (input valid, input start_req, input use_inches, input echo_level,
                  output ready);
endinterface

interface uer_out_if import uer_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                trigger_level;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output status, output distance, input ready);
    modport sink (input valid, input trigger_level, input busy_res, input done_res,
                  input status, input distance, output ready);
endinterface

// ===== rtl/uer_regs.sv =====
// APB-style configuration registers of the ultrasonic echo ranger.
// Depends on uer_pkg for register codes, widths and reset values.
module uer_regs import uer_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    output logic [CFG_TMO_W-1:0] timeout_ticks,
    output logic [RATIO_W-1:0]   ratio_cm,
    output logic [RATIO_W-1:0]   ratio_inch,
    output logic [OVH_W-1:0]     overhead_ticks
);

    logic [CFG_TMO_W-1:0] timeout_reg;
    logic [RATIO_W-1:0]   ratio_cm_reg;
    logic [RATIO_W-1:0]   ratio_inch_reg;
    logic [OVH_W-1:0]     overhead_reg;
    logic                 wr_en;
    logic [1:0]           sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RST;
            ratio_cm_reg   <= RATIO_CM_RST;
            ratio_inch_reg <= RATIO_INCH_RST;
            overhead_reg   <= OVERHEAD_RST;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_TIMEOUT:    timeout_reg    <= pwdata[CFG_TMO_W-1:0];
                REG_RATIO_CM:   ratio_cm_reg   <= pwdata[RATIO_W-1:0];
                REG_RATIO_INCH: ratio_inch_reg <= pwdata[RATIO_W-1:0];
                REG_OVERHEAD:   overhead_reg   <= pwdata[OVH_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_TIMEOUT:    prdata = APB_DW'(timeout_reg);
            REG_RATIO_CM:   prdata = APB_DW'(ratio_cm_reg);
            REG_RATIO_INCH: prdata = APB_DW'(ratio_inch_reg);
            REG_OVERHEAD:   prdata = APB_DW'(overhead_reg);
            default:        prdata = '0;
        endcase
    end

    assign timeout_ticks  = timeout_reg;
    assign ratio_cm       = ratio_cm_reg;
    assign ratio_inch     = ratio_inch_reg;
    assign overhead_ticks = overhead_reg;

endmodule

// ===== rtl/uer_ctrl.sv =====
// Controller of the ultrasonic echo ranger: measurement phase, tick sequencing
// and output handshake. Depends on uer_pkg for command and status types.
module uer_ctrl import uer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic start_req,
    input  logic echo_level,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LOW     = 3'd1;
    localparam logic [2:0] PH_HIGH    = 3'd2;
    localparam logic [2:0] PH_WAIT    = 3'd3;
    localparam logic [2:0] PH_MEASURE = 3'd4;

    localparam logic [1:0] ST_TAKE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [2:0] phase_reg, phase_next;
    logic [1:0] st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    logic       take;

    assign in_ready  = (st_reg == ST_TAKE);
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;

        cmd.tmr_op      = TMR_HOLD;
        cmd.wc_op       = WC_HOLD;
        cmd.units_load  = 1'b0;
        cmd.res_load    = 1'b0;
        cmd.res_trig    = 1'b0;
        cmd.res_busy    = 1'b0;
        cmd.res_done    = 1'b0;
        cmd.res_status  = STATUS_OK;
        cmd.res_dist_en = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.out_load    = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_TAKE:
            begin
                if (take)
                begin
                    cmd.res_load = 1'b1;
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (start_req)
                            begin
                                cmd.units_load = 1'b1;
                                cmd.tmr_op     = TMR_SET1;
                                cmd.wc_op      = WC_CLEAR;
                                phase_next     = PH_LOW;
                            end
                        end
                        PH_LOW:
                        begin
                            if (sts.tmr_ge_low)
                            begin
                                cmd.tmr_op = TMR_CLEAR;
                                phase_next = PH_HIGH;
                            end
                            else
                            begin
                                cmd.tmr_op = TMR_INCR;
                            end
                        end
                        PH_HIGH:
                        begin
                            cmd.res_trig = 1'b1;
                            if (sts.tmr_ge_high)
                            begin
                                cmd.tmr_op = TMR_CLEAR;
                                phase_next = PH_WAIT;
                            end
                            else
                            begin
                                cmd.tmr_op = TMR_INCR;
                            end
                        end
                        PH_WAIT:
                        begin
                            if (echo_level)
                            begin
                                cmd.wc_op = WC_SET1;
                                if (sts.tmo_zero)
                                begin
                                    phase_next     = PH_IDLE;
                                    cmd.res_done   = 1'b1;
                                    cmd.res_status = STATUS_OUT_OF_RANGE;
                                end
                                else
                                begin
                                    phase_next = PH_MEASURE;
                                end
                            end
                            else if (sts.tmr_ge_tmo)
                            begin
                                phase_next     = PH_IDLE;
                                cmd.res_done   = 1'b1;
                                cmd.res_status = STATUS_NO_ECHO;
                            end
                            else
                            begin
                                cmd.tmr_op = TMR_INCR;
                            end
                        end
                        PH_MEASURE:
                        begin
                            if (echo_level)
                            begin
                                if (sts.wc_ge_tmo)
                                begin
                                    phase_next     = PH_IDLE;
                                    cmd.res_done   = 1'b1;
                                    cmd.res_status = STATUS_OUT_OF_RANGE;
                                end
                                else
                                begin
                                    cmd.wc_op = WC_INCR;
                                end
                            end
                            else
                            begin
                                phase_next      = PH_IDLE;
                                cmd.res_done    = 1'b1;
                                cmd.res_status  = STATUS_OK;
                                cmd.res_dist_en = 1'b1;
                                cmd.div_start   = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                    cmd.res_busy = (phase_next != PH_IDLE);
                    st_next      = cmd.div_start ? ST_DIV : ST_PUSH;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    st_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    st_next        = ST_TAKE;
                end
            end
            default:
            begin
                st_next = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            st_reg        <= ST_TAKE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/uer_dp.sv =====
// Datapath of the ultrasonic echo ranger: timers, width counter, serial
// divider and result registers. Depends on uer_pkg for types and widths.
module uer_dp import uer_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 use_inches,
    input  logic [CFG_TMO_W-1:0] timeout_ticks,
    input  logic [RATIO_W-1:0]   ratio_cm,
    input  logic [RATIO_W-1:0]   ratio_inch,
    input  logic [OVH_W-1:0]     overhead_ticks,
    output logic                 trigger_level,
    output logic                 busy_res,
    output logic                 done_res,
    output logic [STATUS_W-1:0]  status,
    output logic [DIST_W-1:0]    distance
);

    localparam int DW = TIMER_BITS - 1 + FRAC_BITS;
    localparam int CW = $clog2(DW);
    localparam int TW = (TIMER_BITS > CFG_TMO_W) ? TIMER_BITS : CFG_TMO_W;
    localparam int QW = (DW > DIST_W) ? DW : DIST_W;

    logic [TIMER_BITS-1:0] phase_timer_reg, phase_timer_next;
    logic [TIMER_BITS-1:0] width_count_reg, width_count_next;
    logic                  units_reg, units_next;

    logic [TW-1:0]         tmo_ext;
    logic [TIMER_BITS-1:0] tmo;
    logic [TIMER_BITS-1:0] ovh;
    logic [TIMER_BITS-1:0] w_sub;
    logic [DW-1:0]         dividend;
    logic [RATIO_W-1:0]    ratio_sel;
    logic [RATIO_W-1:0]    divisor;

    logic [DW-1:0]         quot_reg;
    logic [RATIO_W-1:0]    rem_reg;
    logic [RATIO_W-1:0]    dvs_reg;
    logic [CW-1:0]         cnt_reg;
    logic [RATIO_W:0]      rem_sh;
    logic [RATIO_W:0]      rem_diff;
    logic                  q_bit;

    logic [QW-1:0]         q_ext;
    logic [DIST_W-1:0]     dist_val;

    logic                  pend_trig_reg;
    logic                  pend_busy_reg;
    logic                  pend_done_reg;
    logic [STATUS_W-1:0]   pend_status_reg;
    logic                  pend_dist_en_reg;

    logic                  out_trig_reg;
    logic                  out_busy_reg;
    logic                  out_done_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [DIST_W-1:0]     out_dist_reg;

    // limit the timeout to what the counters can hold
    assign tmo_ext = TW'(timeout_ticks);
    assign tmo     = ((tmo_ext >> TIMER_BITS) != '0) ? '1 : tmo_ext[TIMER_BITS-1:0];

    assign sts.tmr_ge_low  = (phase_timer_reg >= TIMER_BITS'(TRIG_LOW_TICKS - 1));
    assign sts.tmr_ge_high = (phase_timer_reg >= TIMER_BITS'(TRIG_HIGH_TICKS - 1));
    assign sts.tmr_ge_tmo  = (phase_timer_reg >= tmo);
    assign sts.wc_ge_tmo   = (width_count_reg >= tmo);
    assign sts.tmo_zero    = (tmo == '0);
    assign sts.div_last    = (cnt_reg == CW'(DW - 1));

    always_comb
    begin
        case (cmd.tmr_op)
            TMR_CLEAR: phase_timer_next = '0;
            TMR_SET1:  phase_timer_next = TIMER_BITS'(1);
            TMR_INCR:  phase_timer_next = phase_timer_reg + TIMER_BITS'(1);
            default:   phase_timer_next = phase_timer_reg;
        endcase
        case (cmd.wc_op)
            WC_CLEAR: width_count_next = '0;
            WC_SET1:  width_count_next = TIMER_BITS'(1);
            WC_INCR:  width_count_next = width_count_reg + TIMER_BITS'(1);
            default:  width_count_next = width_count_reg;
        endcase
        units_next = cmd.units_load ? use_inches : units_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_timer_reg <= '0;
            width_count_reg <= '0;
            units_reg       <= 1'b0;
        end
        else
        begin
            phase_timer_reg <= phase_timer_next;
            width_count_reg <= width_count_next;
            units_reg       <= units_next;
        end
    end

    // dividend: half of the corrected echo width, scaled to fixed point
    assign ovh       = TIMER_BITS'(overhead_ticks);
    assign w_sub     = (width_count_reg > ovh) ? (width_count_reg - ovh) : '0;
    assign dividend  = DW'(w_sub[TIMER_BITS-1:1]) << FRAC_BITS;
    assign ratio_sel = units_reg ? ratio_inch : ratio_cm;
    assign divisor   = (ratio_sel == '0) ? RATIO_W'(1) : ratio_sel;

    // restoring divider, one quotient bit per step
    assign rem_sh   = {rem_reg, quot_reg[DW-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign q_bit    = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[DW-2:0], q_bit};
            rem_reg  <= q_bit ? rem_diff[RATIO_W-1:0] : rem_sh[RATIO_W-1:0];
        end
    end

    // saturate the quotient to the distance field
    assign q_ext    = QW'(quot_reg);
    assign dist_val = ((q_ext >> DIST_W) != '0) ? '1 : q_ext[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            pend_trig_reg    <= cmd.res_trig;
            pend_busy_reg    <= cmd.res_busy;
            pend_done_reg    <= cmd.res_done;
            pend_status_reg  <= cmd.res_status;
            pend_dist_en_reg <= cmd.res_dist_en;
        end
        if (cmd.out_load)
        begin
            out_trig_reg   <= pend_trig_reg;
            out_busy_reg   <= pend_busy_reg;
            out_done_reg   <= pend_done_reg;
            out_status_reg <= pend_status_reg;
            out_dist_reg   <= pend_dist_en_reg ? dist_val : '0;
        end
    end

    assign trigger_level = out_trig_reg;
    assign busy_res      = out_busy_reg;
    assign done_res      = out_done_reg;
    assign status        = out_status_reg;
    assign distance      = out_dist_reg;

endmodule

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
// Ultrasonic echo ranger: each input transfer is one microsecond tick and gives
// exactly one result transfer. A tick is evaluated into the pending result
// registers and then moved into the output register once that is free; the tick
// that ends a good measurement first runs through the restoring divider, which
// produces one quotient bit per cycle. The next tick is accepted while the
// previous result still waits in the output register.
// Depends on uer_pkg, uer_if, uer_regs, uer_ctrl and uer_dp.
module ultrasonic_echo_ranger_core import uer_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    uer_in_if.sink            in_ch,
    uer_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cmd_t                 cmd;
    sts_t                 sts;
    logic [CFG_TMO_W-1:0] timeout_ticks;
    logic [RATIO_W-1:0]   ratio_cm;
    logic [RATIO_W-1:0]   ratio_inch;
    logic [OVH_W-1:0]     overhead_ticks;

    uer_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .timeout_ticks  (timeout_ticks),
        .ratio_cm       (ratio_cm),
        .ratio_inch     (ratio_inch),
        .overhead_ticks (overhead_ticks)
    );

    uer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .start_req  (in_ch.start_req),
        .echo_level (in_ch.echo_level),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    uer_dp #(
        .TIMER_BITS (TIMER_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .use_inches     (in_ch.use_inches),
        .timeout_ticks  (timeout_ticks),
        .ratio_cm       (ratio_cm),
        .ratio_inch     (ratio_inch),
        .overhead_ticks (overhead_ticks),
        .trigger_level  (out_ch.trigger_level),
        .busy_res       (out_ch.busy_res),
        .done_res       (out_ch.done_res),
        .status         (out_ch.status),
        .distance       (out_ch.distance)
    );

endmodule

// ===== rtl/uer_chk.sv =====
// Port-level checker for the ultrasonic echo ranger core, bound to the top level.
// Depends on uer_pkg and ultrasonic_echo_ranger_core_assert.svh.
`include "ultrasonic_echo_ranger_core_assert.svh"

module uer_chk import uer_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                trigger_level,
    input logic                busy_res,
    input logic                done_res,
    input logic [STATUS_W-1:0] status,
    input logic [DIST_W-1:0]   distance
);

    `UER_ASSERT_NOW(a_done_ends_busy, out_valid && done_res, !busy_res, "done while still busy")
    `UER_ASSERT_NOW(a_quiet_fields, out_valid && !done_res, status == STATUS_OK && distance == '0, "status or distance set without done")
    `UER_ASSERT_NOW(a_trig_in_meas, out_valid && trigger_level, busy_res && !done_res, "trigger outside a measurement")
    `UER_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance) && $stable(status) && $stable(done_res), "stalled result changed")

endmodule

bind ultrasonic_echo_ranger_core uer_chk u_uer_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .trigger_level (out_ch.trigger_level),
    .busy_res      (out_ch.busy_res),
    .done_res      (out_ch.done_res),
    .status        (out_ch.status),
    .distance      (out_ch.distance)
);
